// ===== hdl/shvie_pkg.sv =====
// Shared types and codes for the shadow volume index emitter.
// Used by shadow_volume_index_emitter; no other dependencies.
`default_nettype none

package shvie_pkg;

    localparam int VERT_W = 16;

    // width that far-index sums wrap at
    localparam int INDEX_BITS = 16;

    // input item actions
    localparam logic [1:0] ACT_EDGE      = 2'd0;
    localparam logic [1:0] ACT_DARK_TRI  = 2'd1;
    localparam logic [1:0] ACT_LIGHT_TRI = 2'd2;
    localparam logic [1:0] ACT_GROUP     = 2'd3;

    // emitted triangle kinds
    localparam logic [1:0] KIND_SIDE  = 2'd0;
    localparam logic [1:0] KIND_DARK  = 2'd1;
    localparam logic [1:0] KIND_LIGHT = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_DIRECTIONAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRUDE_TO_INFINITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INCLUDE_DARK_CAP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INCLUDE_LIGHT_CAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN_DARK_CAP        = 3'd4;

    typedef struct packed {
        logic [1:0]        action;
        logic [VERT_W-1:0] vert_a;
        logic [VERT_W-1:0] vert_b;
        logic [VERT_W-1:0] vert_c;
        logic              facing_first;
        logic              facing_second;
        logic              degenerate_edge;
        logic [VERT_W-1:0] group_vertex_count;
    } in_item_t;

    typedef struct packed {
        logic [VERT_W-1:0] index_one;
        logic [VERT_W-1:0] index_two;
        logic [VERT_W-1:0] index_three;
        logic [1:0]        tri_kind;
        logic              index_overflow;
        logic              last_of_item;
    } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/shadow_volume_index_emitter.sv =====
// Top level of the shadow volume index emitter: edge classification,
// far-index adders, a three-slot triangle buffer and the output register.
// Depends on shvie_pkg.
`default_nettype none

// An accepted item is classified and all of its triangles (up to three for a
// silhouette edge: two sides and a fan dark-cap triangle) are computed in the
// accept cycle and parked in a three-slot buffer. The buffer drains one
// triangle per cycle into the output register, stalling while a result waits
// on m_ready. A new item is taken in the same cycle the last parked triangle
// moves to the output register, so items stream back to back while the
// previous result still waits on m_ready. Items that emit nothing (group
// starts, non-silhouette edges, back-facing caps) leave the buffer empty, so
// s_ready stays high for the next item.
// Far indices are near + group vertex count; index_overflow flags a sum that
// does not fit in INDEX_BITS bits. Configuration writes are taken at any time
// (cfg_ready is held high) and belong in idle periods.
module shadow_volume_index_emitter (
    input  wire                                   aclk,
    input  wire                                   aresetn,

    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  shvie_pkg::in_item_t                   s_data,

    output logic                                  m_valid,
    input  wire                                   m_ready,
    output shvie_pkg::out_item_t                  m_data,

    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire [shvie_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire                                   cfg_wdata
);
    import shvie_pkg::*;

    localparam int SUM_W = INDEX_BITS + 1;

    // configuration
    logic light_directional_reg, extrude_to_infinity_reg;
    logic include_dark_cap_reg, include_light_cap_reg, fan_dark_cap_reg;

    // block state
    logic [VERT_W-1:0] group_count_reg, group_count_next;
    logic              first_fan_pending_reg, first_fan_pending_next;
    logic [VERT_W-1:0] fan_anchor_reg, fan_anchor_next;

    // triangle buffer and output stage
    out_item_t slot_reg [3];
    out_item_t slot_next [3];
    logic [2:0] mask_reg, mask_next;
    logic [2:0] new_mask;
    out_item_t  new_slot [3];
    out_item_t  out_reg, out_next;
    logic       m_valid_reg, m_valid_next;

    logic       s_fire, load_out;
    logic [2:0] mask_left;
    out_item_t  sel_slot;

    // far-index arithmetic
    logic [VERT_W-1:0] v0, v1, f0, f1, fc;
    logic [SUM_W-1:0]  sum0, sum1, sumc;
    logic              ovf0, ovf1, ovfc, silhouette;

    always_comb begin
        v0   = s_data.facing_first ? s_data.vert_a : s_data.vert_b;
        v1   = s_data.facing_first ? s_data.vert_b : s_data.vert_a;
        sum0 = SUM_W'(v0) + SUM_W'(group_count_reg);
        sum1 = SUM_W'(v1) + SUM_W'(group_count_reg);
        sumc = SUM_W'(s_data.vert_c) + SUM_W'(group_count_reg);
        ovf0 = sum0[INDEX_BITS];
        ovf1 = sum1[INDEX_BITS];
        ovfc = sumc[INDEX_BITS];
        f0   = sum0[VERT_W-1:0];
        f1   = sum1[VERT_W-1:0];
        fc   = sumc[VERT_W-1:0];
        silhouette = s_data.degenerate_edge ? s_data.facing_first
                                            : (s_data.facing_first ^ s_data.facing_second);
    end

    // classify the incoming item and build its triangles
    always_comb begin
        new_mask               = 3'b000;
        new_slot[0]            = '0;
        new_slot[1]            = '0;
        new_slot[2]            = '0;
        group_count_next       = group_count_reg;
        first_fan_pending_next = first_fan_pending_reg;
        fan_anchor_next        = fan_anchor_reg;
        case (s_data.action)
            ACT_EDGE: begin
                if (silhouette) begin
                    new_mask[0] = 1'b1;
                    new_slot[0] = '{v1, v0, f0, KIND_SIDE, ovf0, 1'b0};
                    new_mask[1] = !(light_directional_reg && extrude_to_infinity_reg);
                    new_slot[1] = '{f0, f1, v1, KIND_SIDE, ovf0 | ovf1, 1'b0};
                    if (fan_dark_cap_reg && include_dark_cap_reg) begin
                        if (first_fan_pending_reg) begin
                            fan_anchor_next        = f0;
                            first_fan_pending_next = 1'b0;
                        end else begin
                            new_mask[2] = 1'b1;
                            new_slot[2] = '{fan_anchor_reg, f1, f0, KIND_DARK,
                                            ovf0 | ovf1, 1'b0};
                        end
                    end
                end
            end
            ACT_DARK_TRI: begin
                // facing_first is required, so v0 = vert_a and v1 = vert_b
                if (include_dark_cap_reg && !fan_dark_cap_reg && s_data.facing_first) begin
                    new_mask[0] = 1'b1;
                    new_slot[0] = '{f1, f0, fc, KIND_DARK, ovf0 | ovf1 | ovfc, 1'b0};
                end
            end
            ACT_LIGHT_TRI: begin
                if (include_light_cap_reg && s_data.facing_first) begin
                    new_mask[0] = 1'b1;
                    new_slot[0] = '{s_data.vert_a, s_data.vert_b, s_data.vert_c,
                                    KIND_LIGHT, 1'b0, 1'b0};
                end
            end
            ACT_GROUP: begin
                group_count_next       = s_data.group_vertex_count;
                first_fan_pending_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // drain: lowest pending slot goes to the output register
    always_comb begin
        sel_slot  = slot_reg[2];
        mask_left = 3'b000;
        if (mask_reg[0]) begin
            sel_slot  = slot_reg[0];
            mask_left = {mask_reg[2:1], 1'b0};
        end else if (mask_reg[1]) begin
            sel_slot  = slot_reg[1];
            mask_left = {mask_reg[2], 2'b00};
        end
        sel_slot.last_of_item = (mask_left == 3'b000);

        load_out = (mask_reg != 3'b000) && (!m_valid_reg || m_ready);
        s_ready  = (mask_reg == 3'b000) || (load_out && mask_left == 3'b000);
        s_fire   = s_valid && s_ready;

        mask_next    = load_out ? mask_left : mask_reg;
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        slot_next[2] = slot_reg[2];
        if (s_fire) begin
            mask_next    = new_mask;
            slot_next[0] = new_slot[0];
            slot_next[1] = new_slot[1];
            slot_next[2] = new_slot[2];
        end

        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (load_out) begin
            out_next     = sel_slot;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_directional_reg   <= 1'b0;
            extrude_to_infinity_reg <= 1'b0;
            include_dark_cap_reg    <= 1'b0;
            include_light_cap_reg   <= 1'b0;
            fan_dark_cap_reg        <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LIGHT_DIRECTIONAL:   light_directional_reg   <= cfg_wdata;
                CFG_EXTRUDE_TO_INFINITY: extrude_to_infinity_reg <= cfg_wdata;
                CFG_INCLUDE_DARK_CAP:    include_dark_cap_reg    <= cfg_wdata;
                CFG_INCLUDE_LIGHT_CAP:   include_light_cap_reg   <= cfg_wdata;
                CFG_FAN_DARK_CAP:        fan_dark_cap_reg        <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_count_reg       <= '0;
            first_fan_pending_reg <= 1'b1;
            fan_anchor_reg        <= '0;
            mask_reg              <= 3'b000;
            m_valid_reg           <= 1'b0;
        end else begin
            if (s_fire) begin
                group_count_reg       <= group_count_next;
                first_fan_pending_reg <= first_fan_pending_next;
                fan_anchor_reg        <= fan_anchor_next;
            end
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
        slot_reg[2] <= slot_next[2];
        out_reg     <= out_next;
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

endmodule

`default_nettype wire

// ===== bench/tb_shadow_volume_index_emitter.sv =====
// Testbench for shadow_volume_index_emitter: directed and random edge, cap and
// group items under several register settings, checked by a scoreboard class.
// Depends on shvie_pkg and the shadow_volume_index_emitter RTL.
`timescale 1ns / 1ps

module tb_shadow_volume_index_emitter;

    import shvie_pkg::*;

    class shadow_tri_predictor;
        bit        light_dir;
        bit        extrude_inf;
        bit        dark_cap_on;
        bit        light_cap_on;
        bit        fan_mode;
        bit [15:0] vert_count;
        bit        fan_pending;
        bit [15:0] fan_anchor;
        out_item_t expected_tris[$];
        int        errors;

        function new();
            fan_pending = 1'b1;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, bit val);
            case (idx)
                CFG_LIGHT_DIRECTIONAL:   light_dir = val;
                CFG_EXTRUDE_TO_INFINITY: extrude_inf = val;
                CFG_INCLUDE_DARK_CAP:    dark_cap_on = val;
                CFG_INCLUDE_LIGHT_CAP:   light_cap_on = val;
                CFG_FAN_DARK_CAP:        fan_mode = val;
                default: ;
            endcase
        endfunction

        // far index; bit 16 is the carry out of the 16-bit sum
        function bit [16:0] far_sum(bit [15:0] near_idx);
            return {1'b0, near_idx} + {1'b0, vert_count};
        endfunction

        // notes an accepted input transfer, returns the number of triangles it causes
        function int note_item(in_item_t it);
            out_item_t tris[3];
            int        n;
            bit [15:0] v0, v1;
            bit [16:0] f0, f1, f2;
            bit        silhouette;
            n = 0;
            case (it.action)
                ACT_GROUP: begin
                    vert_count  = it.group_vertex_count;
                    fan_pending = 1'b1;
                end
                ACT_EDGE: begin
                    silhouette = it.degenerate_edge ? it.facing_first
                                                    : (it.facing_first != it.facing_second);
                    if (silhouette) begin
                        v0 = it.facing_first ? it.vert_a : it.vert_b;
                        v1 = it.facing_first ? it.vert_b : it.vert_a;
                        f0 = far_sum(v0);
                        f1 = far_sum(v1);
                        tris[n] = '{v1, v0, f0[15:0], KIND_SIDE, f0[16], 1'b0};
                        n++;
                        if (!(light_dir && extrude_inf)) begin
                            tris[n] = '{f0[15:0], f1[15:0], v1, KIND_SIDE,
                                        f0[16] | f1[16], 1'b0};
                            n++;
                        end
                        if (fan_mode && dark_cap_on) begin
                            if (fan_pending) begin
                                fan_anchor  = f0[15:0];
                                fan_pending = 1'b0;
                            end else begin
                                tris[n] = '{fan_anchor, f1[15:0], f0[15:0], KIND_DARK,
                                            f0[16] | f1[16], 1'b0};
                                n++;
                            end
                        end
                    end
                end
                ACT_DARK_TRI: begin
                    if (dark_cap_on && !fan_mode && it.facing_first) begin
                        f0 = far_sum(it.vert_a);
                        f1 = far_sum(it.vert_b);
                        f2 = far_sum(it.vert_c);
                        tris[n] = '{f1[15:0], f0[15:0], f2[15:0], KIND_DARK,
                                    f0[16] | f1[16] | f2[16], 1'b0};
                        n++;
                    end
                end
                ACT_LIGHT_TRI: begin
                    if (light_cap_on && it.facing_first) begin
                        tris[n] = '{it.vert_a, it.vert_b, it.vert_c, KIND_LIGHT,
                                    1'b0, 1'b0};
                        n++;
                    end
                end
                default: ;
            endcase
            if (n > 0)
                tris[n-1].last_of_item = 1'b1;
            for (int i = 0; i < n; i++)
                expected_tris.push_back(tris[i]);
            return n;
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_tris.size() == 0) begin
                errors++;
                $display("%0t: triangle with none expected, got %h", $time, got);
                return;
            end
            want = expected_tris.pop_front();
            check_field("index_one", want.index_one, got.index_one);
            check_field("index_two", want.index_two, got.index_two);
            check_field("index_three", want.index_three, got.index_three);
            check_field("tri_kind", want.tri_kind, got.tri_kind);
            check_field("index_overflow", want.index_overflow, got.index_overflow);
            check_field("last_of_item", want.last_of_item, got.last_of_item);
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 33;
    localparam int NUM_PHASES      = 6;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic                 cfg_wdata = 1'b0;

    shadow_tri_predictor predictor = new();
    idle_mode_t idle_mode = IDLE_NONE;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int idle_cycles = 0;

    shadow_volume_index_emitter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int send_idle_pct();
        case (idle_mode)
            IDLE_SEND: return 65;
            IDLE_BOTH: return 24;
            default:   return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (idle_mode)
            IDLE_RECV: return 65;
            IDLE_BOTH: return 24;
            default:   return 0;
        endcase
    endfunction

    function automatic in_item_t mk(logic [1:0] act, logic [15:0] a, logic [15:0] b,
                                    logic [15:0] c, bit ff, bit fs, bit deg,
                                    logic [15:0] cnt);
        in_item_t it;
        it = '{act, a, b, c, ff, fs, deg, cnt};
        return it;
    endfunction

    function automatic logic [15:0] pick_vert();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(15));
            3:       return 16'hFFF0 + 16'($urandom_range(15));
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // mostly silhouette edges and front-facing caps, with the rest as noise
    function automatic in_item_t random_item();
        in_item_t it;
        int       r;
        it.vert_a             = pick_vert();
        it.vert_b             = pick_vert();
        it.vert_c             = pick_vert();
        it.group_vertex_count = pick_vert();
        it.facing_first       = 1'($urandom_range(1));
        it.facing_second      = 1'($urandom_range(1));
        it.degenerate_edge    = ($urandom_range(3) == 0);
        r = $urandom_range(99);
        if (r < 55) begin
            it.action = ACT_EDGE;
            if ($urandom_range(99) < 80) begin
                if (it.degenerate_edge)
                    it.facing_first = 1'b1;
                else
                    it.facing_second = ~it.facing_first;
            end
        end else if (r < 90) begin
            it.action = (r < 72) ? ACT_DARK_TRI : ACT_LIGHT_TRI;
            if ($urandom_range(3) != 0)
                it.facing_first = 1'b1;
        end else begin
            it.action = ACT_GROUP;
        end
        return it;
    endfunction

    task automatic send_item(input in_item_t it, output int n_tris);
        int pct;
        pct = send_idle_pct();
        if (pct > 0 && $urandom_range(99) < pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < pct);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        n_tris = predictor.note_item(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        predictor.set_reg(idx, val);
    endtask

    // bits: light_directional, extrude_to_infinity, dark cap, light cap, fan
    task automatic apply_config(input logic [4:0] regs);
        write_reg(CFG_LIGHT_DIRECTIONAL, regs[4]);
        write_reg(CFG_EXTRUDE_TO_INFINITY, regs[3]);
        write_reg(CFG_INCLUDE_DARK_CAP, regs[2]);
        write_reg(CFG_INCLUDE_LIGHT_CAP, regs[1]);
        write_reg(CFG_FAN_DARK_CAP, regs[0]);
        cfg_valid <= 1'b0;
    endtask

    // drops s_valid, waits until every expected triangle has been checked, then idles
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (predictor.expected_tris.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_directed_fan();
        int n;
        send_item(mk(ACT_GROUP, 16'h1111, 16'h2222, 16'h3333, 1, 0, 1, 16'h0010), n);
        // first silhouette edge sets the fan anchor and emits no dark-cap triangle
        send_item(mk(ACT_EDGE, 16'h0001, 16'h0002, 16'hABCD, 1, 0, 0, 16'h5555), n);
        // back-facing first triangle swaps the vertices
        send_item(mk(ACT_EDGE, 16'h0003, 16'h0004, 16'h0000, 0, 1, 0, 16'h0000), n);
        send_item(mk(ACT_EDGE, 16'h0005, 16'h0006, 16'hFFFF, 1, 1, 1, 16'hFFFF), n);
        // edges that are not silhouettes, then a front- and a back-facing light cap triangle
        send_item(mk(ACT_EDGE, 16'h0007, 16'h0008, 16'h0000, 0, 1, 1, 16'h0000), n);
        send_item(mk(ACT_EDGE, 16'h0009, 16'h000A, 16'h0000, 1, 1, 0, 16'h0000), n);
        send_item(mk(ACT_EDGE, 16'h000B, 16'h000C, 16'h0000, 0, 0, 0, 16'h0000), n);
        send_item(mk(ACT_LIGHT_TRI, 16'h0000, 16'hFFFF, 16'h1234, 1, 0, 0, 16'h0000), n);
        send_item(mk(ACT_LIGHT_TRI, 16'h0001, 16'h0002, 16'h0003, 0, 1, 1, 16'h0000), n);
        // dark cap items are dropped in fan mode
        send_item(mk(ACT_DARK_TRI, 16'h0001, 16'h0002, 16'h0003, 1, 0, 0, 16'h0000), n);
        send_item(mk(ACT_GROUP, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 16'hFFFF), n);
        // anchor computed with a wrapped sum
        send_item(mk(ACT_EDGE, 16'hFFFF, 16'h0000, 16'h0000, 1, 0, 0, 16'h0000), n);
        send_item(mk(ACT_EDGE, 16'h0000, 16'hFFFF, 16'h0000, 1, 0, 1, 16'h0000), n);
        send_item(mk(ACT_GROUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 1, 16'h0000), n);
        send_item(mk(ACT_EDGE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0, 0, 16'hFFFF), n);
        send_item(mk(ACT_EDGE, 16'h8000, 16'h7FFF, 16'h0000, 1, 0, 1, 16'h0000), n);
    endtask

    task automatic run_directed_plain();
        int n;
        send_item(mk(ACT_GROUP, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 16'h8000), n);
        // directional light extruded to infinity: one side only
        send_item(mk(ACT_EDGE, 16'h8000, 16'h7FFF, 16'h0000, 1, 0, 0, 16'h0000), n);
        send_item(mk(ACT_DARK_TRI, 16'h9000, 16'h0001, 16'h7FFF, 1, 0, 0, 16'h0000), n);
        send_item(mk(ACT_DARK_TRI, 16'h0001, 16'h0002, 16'h0003, 0, 1, 1, 16'h0000), n);
        send_item(mk(ACT_LIGHT_TRI, 16'hFFFF, 16'h0000, 16'hFFFF, 1, 0, 0, 16'h0000), n);
    endtask

    task automatic run_random(input int n_items);
        int       n;
        in_item_t it;
        for (int i = 0; i < n_items; i++) begin
            it = random_item();
            send_item(it, n);
        end
    endtask

    // result side: checks every transfer and drives m_ready
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                predictor.check_result(m_data);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct());
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [4:0] phase_regs [NUM_PHASES];
        idle_mode_t phase_idle [NUM_PHASES];
        phase_regs = '{5'b00111, 5'b11111, 5'b00000, 5'b10110, 5'b01101, 5'b11110};
        phase_idle = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_RECV};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        apply_config(5'b00111);
        run_directed_fan();
        wait_idle();
        apply_config(5'b11110);
        run_directed_plain();
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            apply_config(phase_regs[p]);
            idle_mode = phase_idle[p];
            // long receiver hold-off so the block backs up into its input
            if (p == 4)
                hold_req = hold_req + 1;
            run_random(ITEMS_PER_PHASE);
            wait_idle();
        end

        if (predictor.expected_tris.size() != 0) begin
            predictor.errors++;
            $display("%0t: %0d triangles never arrived", $time,
                     predictor.expected_tris.size());
        end
        if (predictor.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/shvie_pkg.sv
hdl/shadow_volume_index_emitter.sv
bench/tb_shadow_volume_index_emitter.sv
